/* src/sra_pkg.sv */
// ============================================================================
// Stack region allocator package
// Shared word types, status and request codes, and parameter defaults.
// ============================================================================
package sra_pkg;

	// Parameter defaults for the top level.
	localparam int unsigned POOL_BYTES_DEF  = 4096;
	localparam int unsigned BLOCK_SHIFT_DEF = 2;
	localparam int unsigned MAX_ITEMS_DEF   = 64;
	localparam int unsigned PTR_BYTES_DEF   = 2;
	localparam int unsigned NUM_BYTES_DEF   = 4;

	// Fixed field widths of the request and response words.
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned AMOUNT_W = 13;
	localparam int unsigned SLOT_W   = 6;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned BASE_W   = 12;
	localparam int unsigned LENGTH_W = 13;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned USED_W   = 11;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOC_ABS = 2'd2;
	localparam logic [KIND_W-1:0] KIND_LOC_REL = 2'd3;

	// Response status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOB   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic                use_num;
		logic [AMOUNT_W-1:0] amount;
		logic [SLOT_W-1:0]   slot;
	} sra_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BASE_W-1:0]   base_addr;
		logic [LENGTH_W-1:0] length;
		logic [COUNT_W-1:0]  item_count;
		logic [USED_W-1:0]   used_blocks;
	} sra_rsp_t;

endpackage

/* src/stack_region_allocator.sv */
// ============================================================================
// Stack region allocator
// Last-in-first-out allocator of regions in a shared pool, with a table of
// cumulative region end offsets counted in blocks.
// ============================================================================
//
//  Channel   Direction  Handshake            Word
//  --------  ---------  -------------------  ---------------------------------
//  request   in         start high, busy low  req (kind, use_num, amount, slot)
//  response  out        done strobe, 1 cycle  rsp (status, base_addr, length,
//                                                  item_count, used_blocks)
//
// A request word is taken on every clock edge at which start is high; busy
// stays low, so one word can be taken in every cycle.
// The response for a word appears on rsp with done high once the word has
// passed stage one and the response register, and the throughput is one
// word per cycle. In stage one the word and its end table entries sit in
// registers; the end table's read ports are addressed from the incoming
// word and the next count so that the entries arrive together with the word.
// Reset (arst_n low) empties the allocator at once; the end table itself is
// not cleared, since only entries written by an allocate are ever used.
// The receiver cannot stall: each response is shown for exactly one cycle.
//
module stack_region_allocator #(
	parameter int unsigned POOL_BYTES  = sra_pkg::POOL_BYTES_DEF,
	parameter int unsigned BLOCK_SHIFT = sra_pkg::BLOCK_SHIFT_DEF,
	parameter int unsigned MAX_ITEMS   = sra_pkg::MAX_ITEMS_DEF,
	parameter int unsigned PTR_BYTES   = sra_pkg::PTR_BYTES_DEF,
	parameter int unsigned NUM_BYTES   = sra_pkg::NUM_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sra_pkg::sra_req_t req,
	output logic             done,
	output sra_pkg::sra_rsp_t rsp
);
	import sra_pkg::*;

	// Table index, item count and block offset widths.
	localparam int unsigned IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int unsigned END_W = $clog2((POOL_BYTES >> BLOCK_SHIFT) + 1);
	// Compare width for a slot against the item count.
	localparam int unsigned CMP_W = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;

	// Allocate path: the byte count needs at most 16 bits (8191 times 8),
	// the rounded sum one more.
	localparam int unsigned ABYTE_W = AMOUNT_W + 3;
	localparam int unsigned BLK_W   = ABYTE_W + 1;
	localparam int unsigned SUM_W   = ((END_W > BLK_W) ? END_W : BLK_W) + 1;
	localparam int unsigned NEED_W  = SUM_W + BLOCK_SHIFT + 1;

	// Locate path: a region's byte size stays below the pool size. The
	// division by the number width is a multiply by a rounded-up reciprocal;
	// with three extra fraction bits it is exact for every byte size below
	// two to the LEN_W, as the number width is at most eight.
	localparam int unsigned LEN_W    = $clog2(POOL_BYTES);
	localparam int unsigned DIV_SH   = LEN_W + 3;
	localparam int unsigned DIV_M_W  = DIV_SH + 1;
	localparam longint      DIV_M_L  = ((longint'(1) << DIV_SH) + NUM_BYTES - 1) / NUM_BYTES;
	localparam int unsigned PROD_W   = LEN_W + DIV_M_W;

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] live_q;
	logic [END_W-1:0] top_q;
	logic [CNT_W-1:0] live_d;
	logic [END_W-1:0] top_d;

	// Stage one: the request word, its table index and the table entries.
	logic                valid_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic                use_num_s1;
	logic [AMOUNT_W-1:0] amount_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [END_W-1:0]    rd_a_s1;
	logic [END_W-1:0]    rd_b_s1;
	logic                byp_a_s1;
	logic                byp_b_s1;
	logic [END_W-1:0]    byp_data_s1;

	// End table, one write port and two registered read ports.
	logic [END_W-1:0] end_mem [MAX_ITEMS];
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [END_W-1:0] wr_data;
	logic [IDX_W-1:0] addr_a;
	logic [IDX_W-1:0] addr_b;

	logic     accept;
	logic     done_q;
	sra_rsp_t rsp_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ------------------------------------------------------------------
	// Read addressing for the incoming word. For a free or relative locate the
	// index is worked out from the count that the word now in stage one leaves
	// behind, so a free or locate right behind an allocate or free sees the
	// updated stack. Port B reads the region's end, port A the entry below it
	// (the start of a located region, or the new top after a free).
	// ------------------------------------------------------------------
	logic [CMP_W-1:0] idx_wide;

	always_comb begin
		case (req.kind)
			KIND_FREE:    idx_wide = CMP_W'(live_d) - CMP_W'(1);
			KIND_LOC_ABS: idx_wide = CMP_W'(req.slot);
			KIND_LOC_REL: idx_wide = CMP_W'(live_d) - CMP_W'(1) - CMP_W'(req.slot);
			default:      idx_wide = '0;
		endcase
	end

	assign addr_b = idx_wide[IDX_W-1:0];
	assign addr_a = addr_b - IDX_W'(1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			end_mem[wr_addr] <= wr_data;
		end
		rd_a_s1     <= end_mem[addr_a];
		rd_b_s1     <= end_mem[addr_b];
		// An entry written at the same edge is taken from the write data.
		byp_a_s1    <= wr_en && (addr_a == wr_addr);
		byp_b_s1    <= wr_en && (addr_b == wr_addr);
		byp_data_s1 <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= req.kind;
			use_num_s1 <= req.use_num;
			amount_s1  <= req.amount;
			slot_s1    <= req.slot;
			idx_s1     <= addr_b;
		end
	end

	// ------------------------------------------------------------------
	// Stage one: decision, state update and response.
	// ------------------------------------------------------------------
	logic [END_W-1:0]   ent_a;
	logic [END_W-1:0]   ent_b;
	logic [END_W-1:0]   start_blk;
	logic [ABYTE_W-1:0] alloc_bytes;
	logic [BLK_W-1:0]   alloc_round;
	logic [BLK_W-1:0]   alloc_blocks;
	logic [SUM_W-1:0]   alloc_sum;
	logic [NEED_W-1:0]  alloc_need;
	logic               slot_oob;
	logic [END_W-1:0]   span_blk;
	logic [LEN_W-1:0]   span_bytes;
	logic [LEN_W-1:0]   base_bytes;
	logic [PROD_W-1:0]  span_prod;
	logic [LEN_W-1:0]   span_nums;
	logic [LEN_W-1:0]   loc_len;
	logic [STATUS_W-1:0] status;
	logic               loc_ok;

	assign ent_a     = byp_a_s1 ? byp_data_s1 : rd_a_s1;
	assign ent_b     = byp_b_s1 ? byp_data_s1 : rd_b_s1;
	// The region at index zero starts at the pool base.
	assign start_blk = (idx_s1 == '0) ? '0 : ent_a;

	// Requested bytes rounded up to whole blocks, and the pool fit check
	// that keeps room for the pointer bytes at the pool end.
	assign alloc_bytes  = use_num_s1 ? ABYTE_W'(amount_s1) * ABYTE_W'(NUM_BYTES)
	                                 : ABYTE_W'(amount_s1);
	assign alloc_round  = BLK_W'(alloc_bytes) + BLK_W'((1 << BLOCK_SHIFT) - 1);
	assign alloc_blocks = alloc_round >> BLOCK_SHIFT;
	assign alloc_sum    = SUM_W'(top_q) + SUM_W'(alloc_blocks);
	assign alloc_need   = (NEED_W'(alloc_sum) << BLOCK_SHIFT) + NEED_W'(PTR_BYTES);

	// For both locate kinds the slot must lie below the item count.
	assign slot_oob = CMP_W'(slot_s1) >= CMP_W'(live_q);

	assign span_blk   = ent_b - start_blk;
	assign span_bytes = LEN_W'(LEN_W'(span_blk) << BLOCK_SHIFT);
	assign base_bytes = LEN_W'(LEN_W'(start_blk) << BLOCK_SHIFT);
	assign span_prod  = PROD_W'(span_bytes) * PROD_W'(DIV_M_L);
	assign span_nums  = LEN_W'(span_prod >> DIV_SH);
	assign loc_len    = use_num_s1 ? span_nums : span_bytes;

	always_comb begin
		status  = ST_OK;
		loc_ok  = 1'b0;
		wr_en   = 1'b0;
		wr_addr = live_q[IDX_W-1:0];
		wr_data = END_W'(alloc_sum);
		live_d  = live_q;
		top_d   = top_q;
		if (valid_s1) begin
			case (kind_s1)
				KIND_ALLOC: begin
					if (alloc_blocks == '0) begin
						status = ST_OOB;
					end else if (live_q >= CNT_W'(MAX_ITEMS)) begin
						status = ST_OVER;
					end else if (alloc_need >= NEED_W'(POOL_BYTES)) begin
						status = ST_OVER;
					end else begin
						wr_en  = 1'b1;
						live_d = live_q + CNT_W'(1);
						top_d  = END_W'(alloc_sum);
					end
				end
				KIND_FREE: begin
					if (live_q == '0) begin
						status = ST_UNDER;
					end else begin
						live_d = live_q - CNT_W'(1);
						top_d  = start_blk;
					end
				end
				KIND_LOC_ABS, KIND_LOC_REL: begin
					if (slot_oob) begin
						status = ST_OOB;
					end else begin
						loc_ok = 1'b1;
					end
				end
				default: begin
					status = ST_OOB;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			live_q   <= '0;
			top_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			live_q   <= live_d;
			top_q    <= top_d;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q.status      <= status;
			rsp_q.base_addr   <= loc_ok ? BASE_W'(base_bytes) : '0;
			rsp_q.length      <= loc_ok ? LENGTH_W'(loc_len) : '0;
			rsp_q.item_count  <= COUNT_W'(live_d);
			rsp_q.used_blocks <= USED_W'(top_d);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* src/sra_checker.sv */
// ============================================================================
// Stack region allocator port checker
// Watches the allocator's ports and checks response timing and bookkeeping.
// ============================================================================
module sra_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input sra_pkg::sra_req_t req,
	input logic              done,
	input sra_pkg::sra_rsp_t rsp
);
	import sra_pkg::*;

	// Every taken word is answered with a done strobe.
	a_resp_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("taken request word not answered two cycles later");

	// A failed request reports no region.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.base_addr == '0 && rsp.length == '0))
		else $error("failed request reports a region");

	// A failed request right behind another leaves the bookkeeping unchanged.
	a_fail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && rsp.status != ST_OK) |->
		(rsp.item_count == $past(rsp.item_count) &&
		 rsp.used_blocks == $past(rsp.used_blocks)))
		else $error("failed request changed the item count or used blocks");

	// A successful allocate right behind another response adds one item.
	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && rsp.status == ST_OK && $past(req.kind, 2) == KIND_ALLOC)
		|-> (rsp.item_count == $past(rsp.item_count) + COUNT_W'(1)))
		else $error("allocate did not add exactly one item");

	// A successful free right behind another response removes one item.
	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && rsp.status == ST_OK && $past(req.kind, 2) == KIND_FREE)
		|-> (rsp.item_count == $past(rsp.item_count) - COUNT_W'(1)))
		else $error("free did not remove exactly one item");

endmodule

bind stack_region_allocator sra_checker u_sra_checker (.*);

/* test/tb_stack_region_allocator.sv */
// ============================================================================
// Stack region allocator testbench
// Drives request words through the start/busy handshake and checks every
// response word against an independent cycle-free prediction of the region
// table: directed cases for empty, pool-full and table-full conditions, then
// random traffic that alternates between growing and shrinking the stack.
// ============================================================================
module tb_stack_region_allocator;

	import sra_pkg::*;

	// The block is instantiated with its package defaults.
	localparam int POOL_BYTES  = POOL_BYTES_DEF;
	localparam int BLOCK_SHIFT = BLOCK_SHIFT_DEF;
	localparam int MAX_ITEMS   = MAX_ITEMS_DEF;
	localparam int PTR_BYTES   = PTR_BYTES_DEF;
	localparam int NUM_BYTES   = NUM_BYTES_DEF;

	// Far above what the slowest correct run needs.
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	sra_req_t req;
	logic     done;
	sra_rsp_t rsp;

	// Predicted allocator state: cumulative end of each live region, in blocks.
	int region_end [MAX_ITEMS] = '{default: 0};
	int live_count = 0;
	int top_blocks = 0;

	// Responses predicted for accepted request words, oldest first.
	sra_rsp_t expected_rsp [$];
	sra_rsp_t want;
	int       errors = 0;
	int       cycle_count = 0;

	stack_region_allocator uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Works out the response to one request word and advances the predicted
	// table the same way the allocator does.
	function automatic sra_rsp_t compute_response(sra_req_t r);
		sra_rsp_t o;
		int       unit;
		int       bytes;
		int       blocks;
		int       idx;
		int       lo;
		int       hi;
		o = '0;
		o.status = ST_OK;
		unit = r.use_num ? NUM_BYTES : 1;
		idx = -1;
		case (r.kind)
			KIND_ALLOC: begin
				bytes = int'(r.amount) * unit;
				blocks = (bytes + (1 << BLOCK_SHIFT) - 1) >> BLOCK_SHIFT;
				if (blocks == 0) begin
					o.status = ST_OOB;
				end else if (live_count >= MAX_ITEMS) begin
					o.status = ST_OVER;
				end else if ((((top_blocks + blocks) << BLOCK_SHIFT) + PTR_BYTES)
						>= POOL_BYTES) begin
					o.status = ST_OVER;
				end else begin
					top_blocks += blocks;
					region_end[live_count] = top_blocks;
					live_count++;
				end
			end
			KIND_FREE: begin
				if (live_count == 0) begin
					o.status = ST_UNDER;
				end else begin
					live_count--;
					top_blocks = (live_count > 0) ? region_end[live_count - 1] : 0;
				end
			end
			KIND_LOC_ABS: begin
				if (int'(r.slot) < live_count)
					idx = int'(r.slot);
				else
					o.status = ST_OOB;
			end
			KIND_LOC_REL: begin
				if (int'(r.slot) < live_count)
					idx = live_count - int'(r.slot) - 1;
				else
					o.status = ST_OOB;
			end
			default: ;
		endcase
		// Only entries below the live count are ever read here.
		if (idx >= 0) begin
			lo = (idx > 0) ? region_end[idx - 1] : 0;
			hi = region_end[idx];
			o.base_addr = BASE_W'(lo << BLOCK_SHIFT);
			o.length = LENGTH_W'(((hi - lo) << BLOCK_SHIFT) / unit);
		end
		o.item_count = COUNT_W'(live_count);
		o.used_blocks = USED_W'(top_blocks);
		return o;
	endfunction

	function automatic sra_req_t make_req(logic [KIND_W-1:0] kind, logic use_num,
			int amount, int slot);
		sra_req_t r;
		r.kind = kind;
		r.use_num = use_num;
		r.amount = AMOUNT_W'(amount);
		r.slot = SLOT_W'(slot);
		return r;
	endfunction

	// Random request word. Most words are well formed (sizes that fit, slots
	// inside the live range), and the mix leans toward allocate while growing
	// and toward free while shrinking so both limits get reached.
	function automatic sra_req_t random_request(bit growing);
		sra_req_t  r;
		int        pick;
		int        size_pick;
		bit [31:0] noise_bits;
		pick = $urandom_range(0, 99);
		r.use_num = 1'($urandom_range(0, 1));
		r.slot = SLOT_W'($urandom());
		size_pick = $urandom_range(0, 99);
		if (size_pick < 45)
			r.amount = AMOUNT_W'($urandom_range(1, 8));
		else if (size_pick < 70)
			r.amount = AMOUNT_W'($urandom_range(1, 64));
		else if (size_pick < 80)
			r.amount = AMOUNT_W'($urandom_range(256, 4096));
		else if (size_pick < 92)
			r.amount = AMOUNT_W'($urandom());
		else
			r.amount = '0;
		if (growing) begin
			if (pick < 55)
				r.kind = KIND_ALLOC;
			else if (pick < 70)
				r.kind = KIND_FREE;
			else if (pick < 85)
				r.kind = KIND_LOC_ABS;
			else
				r.kind = KIND_LOC_REL;
		end else begin
			if (pick < 15)
				r.kind = KIND_ALLOC;
			else if (pick < 55)
				r.kind = KIND_FREE;
			else if (pick < 78)
				r.kind = KIND_LOC_ABS;
			else
				r.kind = KIND_LOC_REL;
		end
		if (live_count > 0 && $urandom_range(0, 99) < 75)
			r.slot = SLOT_W'($urandom_range(0, live_count - 1));
		// A few words are pure noise over every field.
		if ($urandom_range(0, 99) < 5) begin
			noise_bits = $urandom();
			r = noise_bits[$bits(sra_req_t)-1:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int exp_val, int act_val);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%s: expected %0d, got %0d", what, exp_val, act_val);
	endtask

	// Sends one request word. It is entered just after a falling edge; the
	// sender first idles at random, then holds start high until the word is
	// taken. Start stays high on return so back-to-back words flow.
	task automatic send_word(sra_req_t r, int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (!(start && !busy));
		@(negedge clk);
	endtask

	// Holds off the sender until every predicted response has come back.
	task automatic wait_idle();
		start <= 1'b0;
		while (expected_rsp.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic test_empty_cases();
		send_word(make_req(KIND_FREE, 1'b0, 0, 0), 0);
		send_word(make_req(KIND_LOC_ABS, 1'b0, 0, 0), 0);
		send_word(make_req(KIND_LOC_REL, 1'b1, 0, 0), 0);
		send_word(make_req(KIND_ALLOC, 1'b0, 0, 0), 0);
		send_word(make_req(KIND_ALLOC, 1'b1, 0, 63), 0);
		wait_idle();
	endtask

	task automatic test_alloc_locate_free();
		send_word(make_req(KIND_ALLOC, 1'b0, 1, 0), 0);
		send_word(make_req(KIND_ALLOC, 1'b1, 1, 0), 0);
		send_word(make_req(KIND_ALLOC, 1'b0, 5, 0), 0);
		send_word(make_req(KIND_ALLOC, 1'b1, 3, 0), 0);
		send_word(make_req(KIND_LOC_ABS, 1'b0, 0, 0), 0);
		send_word(make_req(KIND_LOC_ABS, 1'b1, 0, 1), 0);
		send_word(make_req(KIND_LOC_ABS, 1'b1, 0, 2), 0);
		send_word(make_req(KIND_LOC_ABS, 1'b0, 0, 3), 0);
		send_word(make_req(KIND_LOC_REL, 1'b0, 0, 0), 0);
		send_word(make_req(KIND_LOC_REL, 1'b1, 0, 3), 0);
		send_word(make_req(KIND_LOC_ABS, 1'b0, 0, 4), 0);
		send_word(make_req(KIND_LOC_REL, 1'b0, 0, 4), 0);
		send_word(make_req(KIND_LOC_ABS, 1'b1, 0, 63), 0);
		send_word(make_req(KIND_LOC_REL, 1'b1, 0, 63), 0);
		// The largest counts overflow the pool in either unit.
		send_word(make_req(KIND_ALLOC, 1'b0, 8191, 0), 0);
		send_word(make_req(KIND_ALLOC, 1'b1, 8191, 0), 0);
		repeat (4) send_word(make_req(KIND_FREE, 1'b0, 0, 0), 0);
		send_word(make_req(KIND_FREE, 1'b0, 0, 0), 0);
		wait_idle();
	endtask

	// One region fills the pool with as many whole blocks as fit below the
	// pointer reserve; one block more does not fit.
	task automatic test_pool_limit();
		send_word(make_req(KIND_ALLOC, 1'b0, 4092, 0), 0);
		send_word(make_req(KIND_ALLOC, 1'b0, 1, 0), 0);
		send_word(make_req(KIND_LOC_ABS, 1'b1, 0, 0), 0);
		send_word(make_req(KIND_FREE, 1'b0, 0, 0), 0);
		send_word(make_req(KIND_ALLOC, 1'b1, 1023, 0), 0);
		send_word(make_req(KIND_FREE, 1'b0, 0, 0), 0);
		send_word(make_req(KIND_ALLOC, 1'b0, 4093, 0), 0);
		wait_idle();
	endtask

	// Fills every table entry, tries one more, reads both ends, then empties it.
	task automatic test_table_limit();
		repeat (MAX_ITEMS) send_word(make_req(KIND_ALLOC, 1'b0, 1, 0), 0);
		send_word(make_req(KIND_ALLOC, 1'b0, 1, 0), 0);
		send_word(make_req(KIND_LOC_ABS, 1'b0, 0, 63), 0);
		send_word(make_req(KIND_LOC_REL, 1'b0, 0, 63), 0);
		send_word(make_req(KIND_LOC_REL, 1'b1, 0, 0), 0);
		repeat (MAX_ITEMS) send_word(make_req(KIND_FREE, 1'b0, 0, 0), 0);
		send_word(make_req(KIND_FREE, 1'b0, 0, 0), 0);
		wait_idle();
	endtask

	// Random traffic; the growing and shrinking mixes take turns so the stack
	// rises toward its limits and drains back toward empty.
	task automatic test_random_traffic(int idle_pct, int count);
		for (int i = 0; i < count; i++)
			send_word(random_request(((i / 150) % 2) == 0), idle_pct);
		wait_idle();
	endtask

	// Response checker and request predictor. Both sample at the rising edge,
	// where the driven inputs have been stable since the falling edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_rsp.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("response word with none outstanding: %h", rsp);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", int'(want.status), int'(rsp.status));
					if (rsp.base_addr !== want.base_addr)
						report_mismatch("base_addr", int'(want.base_addr),
							int'(rsp.base_addr));
					if (rsp.length !== want.length)
						report_mismatch("length", int'(want.length), int'(rsp.length));
					if (rsp.item_count !== want.item_count)
						report_mismatch("item_count", int'(want.item_count),
							int'(rsp.item_count));
					if (rsp.used_blocks !== want.used_blocks)
						report_mismatch("used_blocks", int'(want.used_blocks),
							int'(rsp.used_blocks));
				end
			end
			if (start && !busy)
				expected_rsp.push_back(compute_response(req));
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("stack_region_allocator: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_cases();
		test_alloc_locate_free();
		test_pool_limit();
		test_table_limit();
		test_random_traffic(27, 500);
		test_random_traffic(55, 500);
		test_random_traffic(0, 500);

		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("stack_region_allocator: match");
		end else begin
			$display("stack_region_allocator: mismatch");
		end
		$finish;
	end

endmodule
